@@ rtl/flbt_pkg.sv @@
// ============================================================================
// flbt_pkg: shared types and constants for the frame-link filter/busy timer
// Holds the beat structs, op codes, CSR indexes and controller state type.
// ============================================================================
package flbt_pkg;

   localparam int unsigned ID_W      = 29;
   localparam int unsigned LOCAL_BIT = 28;
   localparam int unsigned MAC_LSB   = 24;
   localparam int unsigned MAC_W     = 4;
   localparam int unsigned OP_W      = 3;
   localparam int unsigned CSR_IDX_W = 1;

   // op codes
   localparam logic [OP_W-1:0] OP_ADD    = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
   localparam logic [OP_W-1:0] OP_RECV   = 3'd2;
   localparam logic [OP_W-1:0] OP_XMIT   = 3'd3;
   localparam logic [OP_W-1:0] OP_TICK   = 3'd4;
   localparam logic [OP_W-1:0] OP_POLL   = 3'd5;

   // CSR indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IS_MASTER   = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_DUPLEX = 1'd1;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [31:0]     frame_id;
      logic [31:0]     filter_id;
      logic [31:0]     filter_mask;
      logic [3:0]      filter_index;
      logic            write_ok;
   } flbt_req_type;

   typedef struct packed {
      logic             accepted;
      logic             sent;
      logic             nak_valid;
      logic [MAC_W-1:0] nak_mac;
      logic [3:0]       filter_count;
      logic             busy_res;
   } flbt_rsp_type;

   // controller -> datapath commands
   typedef struct packed {
      logic load;    // latch the incoming beat
      logic match;   // register per-entry filter hits
      logic commit;  // update state, register the result
   } flbt_cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_COMMIT
   } flbt_state_type;

endpackage

@@ rtl/flbt_ctrl.sv @@
// ============================================================================
// flbt_ctrl: sequencing controller
// Steps each request through match and commit, and strobes the result.
// ============================================================================
module flbt_ctrl
   import flbt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   output logic         rsp_valid,
   output flbt_cmd_type cmd
);

   flbt_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      busy       = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_MATCH;
            end
         end
         ST_MATCH: begin
            busy      = 1'b1;
            cmd.match = 1'b1;
            state_in  = ST_COMMIT;
         end
         ST_COMMIT: begin
            // commit overlaps the next beat's capture
            cmd.commit = 1'b1;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_MATCH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = cmd.commit;
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/flbt_dp.sv @@
// ============================================================================
// flbt_dp: filter table, busy timer and result datapath
// Filter entries compare in parallel; remove shifts later entries down.
// ============================================================================
module flbt_dp
   import flbt_pkg::*;
#(
   parameter int unsigned MAX_FILTERS = 8,
   parameter int unsigned BUSY_TICKS  = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  flbt_cmd_type         cmd,
   input  flbt_req_type         req_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic                 csr_wdata,
   output flbt_rsp_type         rsp_data
);

   localparam int unsigned CNT_W = $clog2(MAX_FILTERS + 1);
   localparam int unsigned CMP_W = (CNT_W > 4) ? CNT_W : 4;
   localparam int unsigned TMR_W = $clog2(BUSY_TICKS + 1);

   logic is_master_ff, half_duplex_ff;

   flbt_req_type            item_ff;
   logic [ID_W-1:0]         ids_ff   [MAX_FILTERS];
   logic [ID_W-1:0]         ids_in   [MAX_FILTERS];
   logic [ID_W-1:0]         masks_ff [MAX_FILTERS];
   logic [ID_W-1:0]         masks_in [MAX_FILTERS];
   logic [MAX_FILTERS-1:0]  hit_ff, hit_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [MAC_W-1:0]        mac_ff, mac_in;
   logic [TMR_W-1:0]        tmr_ff, tmr_in;
   flbt_rsp_type            rsp_ff, rsp_in;

   logic [CMP_W-1:0] cnt_x, idx_x;
   logic             local_id;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         is_master_ff   <= 1'b0;
         half_duplex_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_IS_MASTER:   is_master_ff   <= csr_wdata;
            CSR_HALF_DUPLEX: half_duplex_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // per-entry hits, live entries only
   always_comb begin
      for (int k = 0; k < MAX_FILTERS; k++) begin
         hit_in[k] = (((ids_ff[k] ^ item_ff.frame_id[ID_W-1:0]) & masks_ff[k]) == '0)
                     && (CMP_W'(k) < cnt_x);
      end
   end

   assign cnt_x    = CMP_W'(count_ff);
   assign idx_x    = CMP_W'(item_ff.filter_index);
   assign local_id = item_ff.frame_id[LOCAL_BIT];

   always_comb begin
      ids_in   = ids_ff;
      masks_in = masks_ff;
      count_in = count_ff;
      mac_in   = mac_ff;
      tmr_in   = tmr_ff;
      rsp_in   = '0;
      case (item_ff.op)
         OP_ADD: begin
            if (cnt_x < CMP_W'(MAX_FILTERS)) begin
               for (int k = 0; k < MAX_FILTERS; k++) begin
                  if (CMP_W'(k) == cnt_x) begin
                     ids_in[k]   = item_ff.filter_id[ID_W-1:0];
                     masks_in[k] = item_ff.filter_mask[ID_W-1:0];
                  end
               end
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_REMOVE: begin
            if (idx_x < cnt_x) begin
               // entries past the new count are dead, so shift blindly
               for (int k = 0; k < MAX_FILTERS - 1; k++) begin
                  if (CMP_W'(k) >= idx_x) begin
                     ids_in[k]   = ids_ff[k+1];
                     masks_in[k] = masks_ff[k+1];
                  end
               end
               count_in = count_ff - CNT_W'(1);
            end
         end
         OP_RECV: begin
            mac_in          = '0;
            tmr_in          = '0;
            rsp_in.accepted = (count_ff == '0) || (|hit_ff);
         end
         OP_XMIT: begin
            if (tmr_ff == '0) begin
               mac_in = local_id ? item_ff.frame_id[MAC_LSB +: MAC_W] : '0;
               if (item_ff.write_ok) begin
                  if (!is_master_ff || (half_duplex_ff && local_id)) begin
                     tmr_in = TMR_W'(BUSY_TICKS);
                  end
                  rsp_in.sent = 1'b1;
               end
            end
         end
         OP_TICK: begin
            if (is_master_ff && (tmr_ff != '0)) begin
               tmr_in = tmr_ff - TMR_W'(1);
            end
         end
         OP_POLL: begin
            if ((mac_ff != '0) && (tmr_ff == '0)) begin
               rsp_in.nak_valid = 1'b1;
               rsp_in.nak_mac   = mac_ff;
               mac_in           = '0;
            end
         end
         default: ;
      endcase
      rsp_in.filter_count = 4'(count_in);
      rsp_in.busy_res     = (tmr_in != '0);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         mac_ff   <= '0;
         tmr_ff   <= '0;
      end else if (cmd.commit) begin
         count_ff <= count_in;
         mac_ff   <= mac_in;
         tmr_ff   <= tmr_in;
      end
   end

   // payload: no reset
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         item_ff <= req_data;
      end
      if (cmd.match) begin
         hit_ff <= hit_in;
      end
      if (cmd.commit) begin
         ids_ff   <= ids_in;
         masks_ff <= masks_in;
         rsp_ff   <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

@@ rtl/frame_link_filter_and_busy_timer.sv @@
// ============================================================================
// frame_link_filter_and_busy_timer: frame-link acceptance filter and busy timer
// Top level: controller plus datapath for filter table, MAC and busy timer.
// ============================================================================
// Usage:
//  - Request beat: drive req_data and raise start; the beat is taken on a
//    rising edge where start is high and busy is low.
//  - op selects add filter, remove filter, receive, transmit, tick or poll.
//  - Every request yields exactly one response beat: rsp_valid is high for
//    one cycle with rsp_data; the receiver cannot stall it.
//  - Response: after the request edge the beat passes the match state (filter
//    match), then commit, which registers the result together with rsp_valid.
//  - A new beat is not taken in the match stage (one compare per filter
//    entry, registered), which busy flags; the next beat may be taken in
//    the commit cycle of the previous one.
//  - CSR port: csr_we/csr_index/csr_wdata write is_master (index 0) and
//    half_duplex (index 1); write only while no request is in flight.
//  - Reset (synchronous, active high) empties the filter table, clears the
//    pending MAC, the busy timer and both CSRs. Filter entries themselves
//    are not cleared; entries past the fill count are never consulted.
// ============================================================================
module frame_link_filter_and_busy_timer
   import flbt_pkg::*;
#(
   parameter int unsigned MAX_FILTERS = 8,
   parameter int unsigned BUSY_TICKS  = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  flbt_req_type         req_data,
   output logic                 rsp_valid,
   output flbt_rsp_type         rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic                 csr_wdata
);

   flbt_cmd_type cmd;

   // sequencing
   flbt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // filter table, timer, result register
   flbt_dp #(
      .MAX_FILTERS (MAX_FILTERS),
      .BUSY_TICKS  (BUSY_TICKS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

   // an accepted beat always enters match in the following cycle
   a_accept_to_match: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted beat did not enter match");

   // match is always followed by a state other than match
   a_match_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("match stage lasted more than one cycle");

   // a response beat follows each match once the commit state has registered it
   a_rsp_after_match: assert property (@(posedge clock) disable iff (reset)
      busy |=> ##1 rsp_valid)
      else $error("missing response beat after match");

   // at most one op-specific flag per response
   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($countones({rsp_data.accepted, rsp_data.sent,
                                 rsp_data.nak_valid}) <= 1))
      else $error("more than one op result flag set");

   // the NAK MAC is zero unless a NAK is reported
   a_mac_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.nak_valid) |-> (rsp_data.nak_mac == '0))
      else $error("nak_mac set without nak_valid");

endmodule
